>>> src/btha_pkg.sv
// ----------------------------------------------------------------------------
// btha_pkg
// Shared types and codes for the block table heap allocator.
// ----------------------------------------------------------------------------
package btha_pkg;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_FREE_RANGE = 2'd2,
        ST_NULL       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FIND,
        S_WALK
    } t_state;

    // flag bit positions of one table entry
    localparam int FLAG_TAKEN = 0;
    localparam int FLAG_FIRST = 1;
    localparam int FLAG_NEXT  = 2;

    localparam logic [2:0] FLAGS_FREE = 3'b000;

    // register index of heap_base
    localparam logic REG_HEAP_BASE = 1'b0;

endpackage

>>> src/block_table_heap_allocator.sv
// ----------------------------------------------------------------------------
// block_table_heap_allocator
// First-fit heap allocator over a table of per-block flags held in one RAM.
// ----------------------------------------------------------------------------
// Results: an immediate reject or null free gives its result in the cycle after
// start; an allocate scans the table for a free run, then marks it, and a free
// steps to the addressed block, then clears the rest of its run.
// Throughput: one item at a time; the table RAM is read and written one entry
// a cycle and sets the figure. Results are strobed for one cycle, no stall.
// Reset: synchronous; a clearing pass then writes every entry free with busy
// high. The APB port is live throughout.
module block_table_heap_allocator #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command channel
    input  logic                   start,
    output logic                   busy,
    input  btha_pkg::t_cmd         i_command,
    input  logic [31:0]            i_size_bytes,
    input  logic [31:0]            i_address,
    // result channel
    output logic                   o_valid,
    output btha_pkg::t_status      o_status,
    output logic [31:0]            o_result_address,
    output logic [10:0]            o_freed_blocks,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import btha_pkg::*;

    localparam int          IW         = $clog2(NUM_BLOCKS);
    localparam longint      HEAP_BYTES = longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES);
    localparam int          RBW        = $clog2(HEAP_BYTES + 1);
    localparam int          FW         = $clog2(NUM_BLOCKS + 1);
    localparam logic [IW-1:0]  LAST    = IW'(NUM_BLOCKS - 1);
    localparam logic [RBW-1:0] BB_R    = RBW'(BLOCK_BYTES);
    localparam logic [32:0]    BB_W    = 33'(BLOCK_BYTES);
    localparam logic [32:0]    HEAP_LIM = 33'(HEAP_BYTES);

    logic [2:0] mem [NUM_BLOCKS];

    t_state          r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_start, n_start;
    logic [IW-1:0]   r_last, n_last;
    logic [31:0]     r_arg, n_arg;
    logic [RBW-1:0]  r_acc, n_acc;
    logic [FW-1:0]   r_freed, n_freed;
    logic [31:0]     r_base;
    logic [2:0]      r_rd_data;

    logic            r_valid, n_valid;
    t_status         r_status, n_status;
    logic [31:0]     r_res_addr, n_res_addr;
    logic [FW-1:0]   r_freed_out, n_freed_out;

    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [2:0]      wr_data;
    logic [IW-1:0]   rd_addr;
    logic [IW-1:0]   idx_next;
    logic [31:0]     diff;
    logic [RBW-1:0]  run_new;
    logic [2:0]      mark_flags;
    logic [31:0]     start_addr;

    assign idx_next   = (r_idx == LAST) ? '0 : r_idx + 1'b1;
    assign diff       = i_address - r_base;
    assign run_new    = r_acc + BB_R;
    assign start_addr = r_base + 32'(64'(r_start) * 64'(BLOCK_BYTES));

    always_comb begin
        mark_flags             = FLAGS_FREE;
        mark_flags[FLAG_TAKEN] = 1'b1;
        mark_flags[FLAG_FIRST] = (r_idx == r_start);
        mark_flags[FLAG_NEXT]  = (r_idx != r_last);
    end

    // table RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_HEAP_BASE) begin
            r_base <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEAP_BASE) ? r_base : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_last      <= n_last;
        r_arg       <= n_arg;
        r_acc       <= n_acc;
        r_freed     <= n_freed;
        r_status    <= n_status;
        r_res_addr  <= n_res_addr;
        r_freed_out <= n_freed_out;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_start     = r_start;
        n_last      = r_last;
        n_arg       = r_arg;
        n_acc       = r_acc;
        n_freed     = r_freed;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_res_addr  = r_res_addr;
        n_freed_out = r_freed_out;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = FLAGS_FREE;
        rd_addr     = r_idx;

        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_res_addr  = '0;
                    n_freed_out = '0;
                    if (i_command == CMD_ALLOC) begin
                        if (i_size_bytes == '0) begin
                            n_valid  = 1'b1;
                            n_status = ST_ALLOC_FAIL;
                        end else begin
                            n_arg   = i_size_bytes;
                            n_acc   = '0;
                            n_idx   = '0;
                            rd_addr = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (i_address == '0) begin
                            n_valid  = 1'b1;
                            n_status = ST_NULL;
                        end else if (i_address < r_base || {1'b0, diff} >= HEAP_LIM) begin
                            n_valid  = 1'b1;
                            n_status = ST_FREE_RANGE;
                        end else begin
                            n_arg   = diff;
                            n_acc   = '0;
                            n_idx   = '0;
                            n_state = S_FIND;
                        end
                    end
                end
            end

            // read data for r_idx arrives here; the next entry is read meanwhile
            S_SCAN: begin
                rd_addr = idx_next;
                n_idx   = idx_next;
                if (r_rd_data[FLAG_TAKEN]) begin
                    n_acc = '0;
                end else begin
                    if (r_acc == '0) begin
                        n_start = r_idx;
                    end
                    n_acc = run_new;
                end
                if (!r_rd_data[FLAG_TAKEN] && 33'(run_new) >= {1'b0, r_arg}) begin
                    n_last  = r_idx;
                    n_idx   = (r_acc == '0) ? r_idx : r_start;
                    n_state = S_MARK;
                end else if (r_idx == LAST) begin
                    n_valid  = 1'b1;
                    n_status = ST_ALLOC_FAIL;
                    n_state  = S_IDLE;
                end
            end

            S_MARK: begin
                wr_en   = 1'b1;
                wr_data = mark_flags;
                if (r_idx == r_last) begin
                    n_valid    = 1'b1;
                    n_status   = ST_OK;
                    n_res_addr = start_addr;
                    n_state    = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // step block by block until the offset lands inside block r_idx
            S_FIND: begin
                if ({1'b0, r_arg} < 33'(r_acc) + BB_W) begin
                    wr_en   = 1'b1;
                    n_freed = FW'(1);
                    if (r_idx == LAST) begin
                        n_valid     = 1'b1;
                        n_status    = ST_OK;
                        n_freed_out = FW'(1);
                        n_state     = S_IDLE;
                    end else begin
                        rd_addr = idx_next;
                        n_idx   = idx_next;
                        n_state = S_WALK;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_acc = run_new;
                end
            end

            // clear while the entry is taken and not the head of another run
            S_WALK: begin
                if (r_rd_data[FLAG_TAKEN] && !r_rd_data[FLAG_FIRST]) begin
                    wr_en   = 1'b1;
                    n_freed = r_freed + 1'b1;
                    if (r_idx == LAST) begin
                        n_valid     = 1'b1;
                        n_status    = ST_OK;
                        n_freed_out = r_freed + 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        rd_addr = idx_next;
                        n_idx   = idx_next;
                    end
                end else begin
                    n_valid     = 1'b1;
                    n_status    = ST_OK;
                    n_freed_out = r_freed;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_result_address = r_res_addr;
    assign o_freed_blocks   = 11'(r_freed_out);

endmodule

>>> sim/tb_block_table_heap_allocator.sv
// ----------------------------------------------------------------------------
// tb_block_table_heap_allocator
// Self-checking bench for the first-fit block table heap allocator. A shadow
// copy of the block flag table predicts the status, address and freed count of
// every accepted command. The APB port moves heap_base through several values,
// extremes included. Directed corner cases come first, then random batches of
// mostly well-formed allocate/free traffic with random idle gaps on the
// command side.
// ----------------------------------------------------------------------------
module tb_block_table_heap_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import btha_pkg::*;

    localparam int NUM_BLOCKS   = 1024;
    localparam int BLOCK_BYTES  = 4096;
    localparam int HEAP_BYTES   = NUM_BLOCKS * BLOCK_BYTES;
    localparam int PHASE_ITEMS  = 95;
    localparam int DRAIN_CYCLES = 2 * NUM_BLOCKS + 4;
    localparam logic [2:0] HEAP_BASE_ADDR = {REG_HEAP_BASE, 2'b00};

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] size;
        logic [31:0] addr;
    } t_heap_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] addr;
        logic [10:0] freed;
    } t_heap_reply;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               start            = 1'b0;
    logic               busy;
    t_cmd               i_command        = CMD_ALLOC;
    logic [31:0]        i_size_bytes     = '0;
    logic [31:0]        i_address        = '0;
    logic               o_valid;
    t_status            o_status;
    logic [31:0]        o_result_address;
    logic [10:0]        o_freed_blocks;
    logic               psel             = 1'b0;
    logic               penable          = 1'b0;
    logic               pwrite           = 1'b0;
    logic [2:0]         paddr            = '0;
    logic [31:0]        pwdata           = '0;
    logic [31:0]        prdata;
    logic               pready;

    // shadow state of the allocator
    logic [2:0]         shadow_flags [NUM_BLOCKS];
    logic [31:0]        shadow_base = '0;

    t_heap_req          req_q [$];
    t_heap_reply        reply_q [$];
    int                 req_sent = 0;
    int                 req_taken = 0;
    int                 mismatch_count = 0;
    int                 gap_left = 0;
    int                 burst_left = 0;
    bit                 calm = 1'b0;

    always #1 i_clk = ~i_clk;

    block_table_heap_allocator #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_size_bytes     (i_size_bytes),
        .i_address        (i_address),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_result_address (o_result_address),
        .o_freed_blocks   (o_freed_blocks),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    // First-fit allocate or run-walking free against the shadow table.
    function automatic t_heap_reply heap_predict(t_cmd cmd, logic [31:0] size,
                                                 logic [31:0] addr);
        t_heap_reply     rep;
        longint unsigned need;
        longint unsigned run;
        longint unsigned idx;
        int              base_blk;
        int              last_blk;
        rep = '{status: ST_ALLOC_FAIL, addr: '0, freed: '0};
        run = 0;
        base_blk = 0;
        if (cmd == CMD_ALLOC) begin
            need = ({32'd0, size} + 64'(BLOCK_BYTES - 1)) / 64'(BLOCK_BYTES);
            if (size == 0 || need > NUM_BLOCKS) begin
                return rep;
            end
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                if (shadow_flags[i][FLAG_TAKEN]) begin
                    run = 0;
                end else begin
                    if (run == 0) begin
                        base_blk = i;
                    end
                    run++;
                    if (run == need) begin
                        last_blk = base_blk + int'(need) - 1;
                        for (int k = base_blk; k <= last_blk; k++) begin
                            shadow_flags[k] = FLAGS_FREE;
                            shadow_flags[k][FLAG_TAKEN] = 1'b1;
                            shadow_flags[k][FLAG_FIRST] = (k == base_blk);
                            shadow_flags[k][FLAG_NEXT]  = (k != last_blk);
                        end
                        rep.status = ST_OK;
                        rep.addr   = shadow_base + 32'(base_blk * BLOCK_BYTES);
                        return rep;
                    end
                end
            end
            return rep;
        end
        if (addr == 0) begin
            rep.status = ST_NULL;
            return rep;
        end
        rep.status = ST_FREE_RANGE;
        if (addr < shadow_base) begin
            return rep;
        end
        idx = 64'((addr - shadow_base) / BLOCK_BYTES);
        if (idx >= NUM_BLOCKS) begin
            return rep;
        end
        // the addressed entry always goes, then walk the rest of the run
        rep.status = ST_OK;
        do begin
            shadow_flags[idx] = FLAGS_FREE;
            rep.freed++;
            idx++;
        end while (idx < NUM_BLOCKS && shadow_flags[idx][FLAG_TAKEN]
                   && !shadow_flags[idx][FLAG_FIRST]);
        return rep;
    endfunction

    // Draw one request; most are allocates or frees aimed at live allocations in the shadow table.
    function automatic t_heap_req next_req();
        t_heap_req   r;
        int          heads [$];
        int          roll;
        int          blk;
        logic [31:0] offs;
        foreach (shadow_flags[n]) begin
            if (shadow_flags[n][FLAG_FIRST]) begin
                heads.push_back(n);
            end
        end
        roll   = $urandom_range(0, 99);
        r.size = $urandom;
        r.addr = $urandom;
        offs   = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, BLOCK_BYTES - 1));
        if (roll < 45 || (roll < 80 && heads.size() == 0)) begin
            r.cmd = CMD_ALLOC;
            roll  = $urandom_range(0, 99);
            if (roll < 80) begin
                r.size = $urandom_range(1, 8 * BLOCK_BYTES);
            end else if (roll < 92) begin
                r.size = $urandom_range(1, 64 * BLOCK_BYTES);
            end else if (roll < 97) begin
                r.size = $urandom_range(1, HEAP_BYTES);
            end
        end else if (roll < 80) begin
            r.cmd  = CMD_FREE;
            blk    = heads[$urandom_range(0, heads.size() - 1)];
            r.addr = shadow_base + 32'(blk * BLOCK_BYTES) + offs;
        end else if (roll < 88) begin
            // land anywhere: mid-run, free entry or head
            r.cmd  = CMD_FREE;
            blk    = $urandom_range(0, NUM_BLOCKS - 1);
            r.addr = shadow_base + 32'(blk * BLOCK_BYTES) + offs;
        end else if (roll < 94) begin
            r.cmd = CMD_FREE;
            case ($urandom_range(0, 3))
                0: r.addr = '0;
                1: r.addr = shadow_base - 1;
                2: r.addr = shadow_base + 32'(HEAP_BYTES) + offs;
                default: r.addr = $urandom;
            endcase
        end else begin
            r.cmd = CMD_ALLOC;
            case ($urandom_range(0, 3))
                0: r.size = '0;
                1: r.size = 32'(HEAP_BYTES);
                2: r.size = 32'(HEAP_BYTES) + 1;
                default: r.size = 32'($urandom_range(1, 4) * BLOCK_BYTES);
            endcase
        end
        return r;
    endfunction

    task automatic push_req(input t_cmd cmd, input logic [31:0] size,
                            input logic [31:0] addr);
        req_q.push_back('{cmd: cmd, size: size, addr: addr});
    endtask

    // Hold until every queued item has been taken and answered.
    task automatic settle();
        while (req_q.size() != 0 || reply_q.size() != 0 || start) begin
            @(posedge i_clk);
        end
    endtask

    // Write heap_base, then read it back.
    task automatic set_heap_base(input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HEAP_BASE_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_base = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pwdata  <= $urandom;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            note_mismatch($sformatf("heap_base readback exp %h got %h", value, prdata));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Present queued items at the falling edge; hold each until taken.
    always @(negedge i_clk) begin : driver
        t_heap_req r;
        if (i_rst_n && !(start && req_taken != req_sent)) begin
            if (gap_left > 0 || req_q.size() == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                start        <= 1'b0;
                i_command    <= t_cmd'($urandom_range(0, 1));
                i_size_bytes <= $urandom;
                i_address    <= $urandom;
            end else begin
                r = req_q.pop_front();
                start        <= 1'b1;
                i_command    <= r.cmd;
                i_size_bytes <= r.size;
                i_address    <= r.addr;
                req_sent++;
                if (burst_left == 0) begin
                    calm       = ($urandom_range(0, 3) == 0);
                    burst_left = $urandom_range(8, 40);
                end
                burst_left--;
                gap_left = calm ? 0 : $urandom_range(0, 11);
            end
        end
    end

    // Check strobed results first, then log any item taken at this edge.
    always @(posedge i_clk) begin : monitor
        t_heap_reply want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (reply_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected result status %0d addr %h freed %0d",
                                            o_status, o_result_address, o_freed_blocks));
                end else begin
                    want = reply_q.pop_front();
                    if (o_status !== want.status) begin
                        note_mismatch($sformatf("status exp %0d got %0d",
                                                want.status, o_status));
                    end
                    if (o_result_address !== want.addr) begin
                        note_mismatch($sformatf("result_address exp %h got %h",
                                                want.addr, o_result_address));
                    end
                    if (o_freed_blocks !== want.freed) begin
                        note_mismatch($sformatf("freed_blocks exp %0d got %0d",
                                                want.freed, o_freed_blocks));
                    end
                end
            end
            if (start && !busy) begin
                reply_q.push_back(heap_predict(i_command, i_size_bytes, i_address));
                req_taken++;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] bases [6];
        logic [31:0] b;
        int          batch;
        int          sent;
        foreach (shadow_flags[n]) begin
            shadow_flags[n] = FLAGS_FREE;
        end
        bases = '{32'h0000_0000, 32'h8000_0000, $urandom, 32'hFFF0_0000,
                  32'hFFFF_FFFF, 32'h0000_3000};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_heap_base(32'h0010_0000);
        b = shadow_base;
        push_req(CMD_ALLOC, 32'd0, $urandom);
        push_req(CMD_ALLOC, 32'hFFFF_FFFF, $urandom);
        push_req(CMD_ALLOC, 32'(HEAP_BYTES) + 1, $urandom);
        push_req(CMD_ALLOC, 32'(HEAP_BYTES), $urandom);
        push_req(CMD_ALLOC, 32'd1, $urandom);                   // heap full
        push_req(CMD_FREE, $urandom, b + 5 * BLOCK_BYTES + 7);  // mid-run to end
        push_req(CMD_FREE, $urandom, b);                        // stops at free entry
        push_req(CMD_FREE, $urandom, 32'd0);
        push_req(CMD_FREE, $urandom, b - 1);
        push_req(CMD_FREE, $urandom, b + 32'(HEAP_BYTES));
        push_req(CMD_FREE, $urandom, 32'hFFFF_FFFF);
        push_req(CMD_ALLOC, 32'd1, $urandom);
        push_req(CMD_ALLOC, 32'(BLOCK_BYTES), $urandom);
        push_req(CMD_ALLOC, 32'(BLOCK_BYTES) + 1, $urandom);
        push_req(CMD_ALLOC, 32'(3 * BLOCK_BYTES), $urandom);
        push_req(CMD_FREE, $urandom, b + BLOCK_BYTES);          // stops at next head
        push_req(CMD_FREE, $urandom, b + BLOCK_BYTES + 100);    // already free
        push_req(CMD_ALLOC, 32'd2, $urandom);                   // fills the hole
        push_req(CMD_FREE, $urandom, b + 2 * BLOCK_BYTES);
        push_req(CMD_ALLOC, 32'(2 * BLOCK_BYTES), $urandom);
        push_req(CMD_FREE, $urandom, b + 32'(HEAP_BYTES) - 1);  // last entry
        push_req(CMD_ALLOC, 32'(1020 * BLOCK_BYTES), $urandom); // no fit
        push_req(CMD_FREE, $urandom, b + 4 * BLOCK_BYTES);
        settle();

        foreach (bases[p]) begin
            set_heap_base(bases[p]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                batch = $urandom_range(1, 4);
                repeat (batch) begin
                    req_q.push_back(next_req());
                end
                sent += batch;
                settle();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (reply_q.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", reply_q.size()));
        end
        if (mismatch_count == 0) begin
            $display("block_table_heap_allocator regression: pass");
        end else begin
            $display("block_table_heap_allocator regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("block_table_heap_allocator regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
src/btha_pkg.sv
src/block_table_heap_allocator.sv
sim/tb_block_table_heap_allocator.sv
